// ===== src/lve_pkg.sv =====
// ----------------------------------------------------------------------------
// lve_pkg
// Shared constants and types of the Laplacian variance estimator.
// ----------------------------------------------------------------------------
`default_nettype none
package lve_pkg;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	// Geometry arithmetic width: holds 8192 and any 12-bit register value.
	localparam int GW = 14;

	localparam int CNT_W = 23;
	localparam int SUM_W = 34;
	localparam int SQ_W  = 43;
	localparam int VAR_W = 28;

	localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_COLOR_MODE     = 3'd2;
	localparam logic [2:0] REG_REGION_X_START = 3'd3;
	localparam logic [2:0] REG_REGION_Y_START = 3'd4;
	localparam logic [2:0] REG_REGION_X_END   = 3'd5;
	localparam logic [2:0] REG_REGION_Y_END   = 3'd6;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] n;
		logic [SUM_W-1:0] sum;
		logic [SQ_W-1:0]  sq;
	} var_req_t;

	typedef struct packed {
		logic             done;
		logic [VAR_W-1:0] variance;
	} var_rsp_t;

endpackage
`default_nettype wire

// ===== src/laplacian_variance_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// laplacian_variance_estimator_unit
// Variance of the 3x3 four-neighbour Laplacian over a region of a frame.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ channel in raster order, one beat per pixel:
// s_tdata holds the three channels, s_tuser marks the first pixel of a
// frame. Registers must be written on the cfg_ channel only while the block
// is idle; the block itself does not enforce this. Each pixel passes an
// accept state that reads the line store RAM, a state that updates the
// window and writes the RAM back, and an accumulate state; the next pixel
// is accepted only after that. After the last pixel of a frame the variance
// unit runs 34 multiply steps and at most 74 divide steps with s_tready low,
// then the result beat is loaded into the m_ output register. If the receiver
// still holds the previous result, the block waits with s_tready low until
// it is taken. An empty region skips the variance unit.
// Reset clears the counters, the sums, the window and the output valid, and
// restores the register defaults; the line store contents are left as is.
// ----------------------------------------------------------------------------
`default_nettype none
module laplacian_variance_estimator_unit #(
	parameter int MAX_WIDTH  = lve_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lve_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [11:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// chan_a, chan_b, chan_c
	input  wire logic [23:0]  s_tdata,
	// frame_start
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// variance_q8, pixel_count, lap_sum, lap_square_sum, zero fill
	output logic      [127:0] m_tdata,
	// region_empty
	output logic              m_tuser
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int HW = $clog2(MAX_HEIGHT);
	localparam int GW = lve_pkg::GW;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_WIN  = 5'b00010,
		S_ACC  = 5'b00100,
		S_MATH = 5'b01000,
		S_LOAD = 5'b10000
	} state_t;

	state_t state_q;

	logic [11:0] fw_q, fh_q, xs_q, ys_q, xe_q, ye_q;
	logic color_q;

	logic [AW-1:0] col_q;
	logic [HW-1:0] row_q;
	logic [7:0] win_q [9];
	logic [lve_pkg::SUM_W-1:0] sum_q;
	logic [lve_pkg::SQ_W-1:0] sq_q;
	logic [lve_pkg::CNT_W-1:0] cnt_q;

	logic [7:0] luma_s1;
	logic [AW-1:0] idx_s1;
	logic counted_s1, last_s1;
	logic signed [10:0] lap_s2;

	logic [lve_pkg::CNT_W-1:0] fin_n_q;
	logic [lve_pkg::SUM_W-1:0] fin_sum_q;
	logic [lve_pkg::SQ_W-1:0] fin_sq_q;
	logic fin_empty_q;

	logic m_tvalid_q;
	logic [127:0] m_tdata_q;
	logic m_tuser_q;

	logic accept;
	logic [7:0] a_ch, b_ch, c_ch, luma;
	logic [9:0] csum;
	logic [19:0] cprod;
	logic [GW-1:0] w, h, col1, row1, cx, cy, xmin, xmax, ymin, ymax;
	logic [GW-1:0] xlo, xhi, ylo, yhi;
	logic [AW-1:0] col_e;
	logic [HW-1:0] row_e;
	logic line_end, last, in_region;
	logic [15:0] ram_rdata;
	logic signed [11:0] lap_full;
	logic signed [21:0] lap_sq;
	logic [lve_pkg::SUM_W-1:0] sum_n;
	logic [lve_pkg::SQ_W-1:0] sq_n;
	logic [lve_pkg::CNT_W-1:0] cnt_n;
	lve_pkg::var_req_t req;
	lve_pkg::var_rsp_t rsp;
	logic out_free;

	assign cfg_ready = 1'b1;
	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	assign a_ch = s_tdata[7:0];
	assign b_ch = s_tdata[15:8];
	assign c_ch = s_tdata[23:16];
	assign csum = 10'(a_ch) + 10'(b_ch) + 10'(c_ch);
	assign cprod = 20'(csum) * 20'd683;
	assign luma = color_q ? cprod[18:11] : a_ch;

	always_comb begin
		w = (fw_q == '0) ? GW'(1) : ((GW'(fw_q) > GW'(MAX_WIDTH)) ? GW'(MAX_WIDTH) : GW'(fw_q));
		h = (fh_q == '0) ? GW'(1) : ((GW'(fh_q) > GW'(MAX_HEIGHT)) ? GW'(MAX_HEIGHT) : GW'(fh_q));
		col_e = s_tuser ? '0 : col_q;
		row_e = s_tuser ? '0 : row_q;
		col1 = GW'(col_e) + 1'b1;
		row1 = GW'(row_e) + 1'b1;
		cx = GW'(col_e) - 1'b1;
		cy = GW'(row_e) - 1'b1;
		line_end = (col1 >= w);
		last = line_end && (row1 >= h);
		xlo = (xs_q < xe_q) ? GW'(xs_q) : GW'(xe_q);
		xhi = (xs_q < xe_q) ? GW'(xe_q) : GW'(xs_q);
		ylo = (ys_q < ye_q) ? GW'(ys_q) : GW'(ye_q);
		yhi = (ys_q < ye_q) ? GW'(ye_q) : GW'(ys_q);
		xmin = (xlo < GW'(1)) ? GW'(1) : xlo;
		ymin = (ylo < GW'(1)) ? GW'(1) : ylo;
		xmax = (xhi > w - 1'b1) ? w - 1'b1 : xhi;
		ymax = (yhi > h - 1'b1) ? h - 1'b1 : yhi;
		in_region = (GW'(col_e) >= GW'(2)) && (GW'(row_e) >= GW'(2)) &&
			(cx >= xmin) && (cx < xmax) && (cy >= ymin) && (cy < ymax);
	end

	lve_ram #(
		.WIDTH(16),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk(clk),
		.we(state_q == S_WIN),
		.waddr(idx_s1),
		.wdata({ram_rdata[7:0], luma_s1}),
		.raddr(col_e),
		.rdata(ram_rdata)
	);

	assign lap_full = 12'(signed'({4'd0, win_q[5]}) <<< 2) - signed'(12'(win_q[2]))
		- signed'(12'(win_q[8])) - signed'(12'(win_q[4])) - signed'(12'(ram_rdata[7:0]));
	assign lap_sq = lap_s2 * lap_s2;
	assign sum_n = sum_q + lve_pkg::SUM_W'(lap_s2);
	assign sq_n = sq_q + lve_pkg::SQ_W'(unsigned'(lap_sq));
	assign cnt_n = cnt_q + 1'b1;

	assign req.start = (state_q == S_MATH) && !rsp.done && (fin_n_q != '0) && !fin_empty_q;
	assign req.n = fin_n_q;
	assign req.sum = fin_sum_q;
	assign req.sq = fin_sq_q;

	lve_var_unit u_var (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 12'd640;
			fh_q <= 12'd480;
			color_q <= 1'b0;
			xs_q <= 12'd0;
			ys_q <= 12'd0;
			xe_q <= 12'd2048;
			ye_q <= 12'd2048;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lve_pkg::REG_FRAME_WIDTH:    fw_q <= cfg_data;
				lve_pkg::REG_FRAME_HEIGHT:   fh_q <= cfg_data;
				lve_pkg::REG_COLOR_MODE:     color_q <= cfg_data[0];
				lve_pkg::REG_REGION_X_START: xs_q <= cfg_data;
				lve_pkg::REG_REGION_Y_START: ys_q <= cfg_data;
				lve_pkg::REG_REGION_X_END:   xe_q <= cfg_data;
				lve_pkg::REG_REGION_Y_END:   ye_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q <= '0;
			row_q <= '0;
			sum_q <= '0;
			sq_q <= '0;
			cnt_q <= '0;
			fin_empty_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (state_q == S_LOAD && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_WIN;
						if (s_tuser) begin
							sum_q <= '0;
							sq_q <= '0;
							cnt_q <= '0;
						end
						col_q <= line_end ? '0 : AW'(col1);
						row_q <= line_end ? (last ? '0 : HW'(row1)) : row_e;
					end
				end
				S_WIN: begin
					for (int r = 0; r < 3; r++) begin
						win_q[r*3] <= win_q[r*3+1];
						win_q[r*3+1] <= win_q[r*3+2];
					end
					win_q[2] <= ram_rdata[15:8];
					win_q[5] <= ram_rdata[7:0];
					win_q[8] <= luma_s1;
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (last_s1) begin
						sum_q <= '0;
						sq_q <= '0;
						cnt_q <= '0;
						fin_empty_q <= counted_s1 ? 1'b0 : (cnt_q == '0);
						state_q <= (counted_s1 || cnt_q != '0) ? S_MATH : S_LOAD;
					end else begin
						if (counted_s1) begin
							sum_q <= sum_n;
							sq_q <= sq_n;
							cnt_q <= cnt_n;
						end
						state_q <= S_IDLE;
					end
				end
				S_MATH: begin
					if (rsp.done) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			luma_s1 <= luma;
			idx_s1 <= col_e;
			counted_s1 <= in_region;
			last_s1 <= last;
		end
		if (state_q == S_WIN) begin
			lap_s2 <= lap_full[10:0];
		end
		if (state_q == S_ACC && last_s1) begin
			fin_n_q <= counted_s1 ? cnt_n : cnt_q;
			fin_sum_q <= counted_s1 ? sum_n : sum_q;
			fin_sq_q <= counted_s1 ? sq_n : sq_q;
		end
		if (state_q == S_LOAD && out_free) begin
			if (fin_empty_q) begin
				m_tdata_q <= '0;
				m_tuser_q <= 1'b1;
			end else begin
				m_tdata_q <= {2'b00, fin_sq_q[41:0], fin_sum_q[32:0], fin_n_q, rsp.variance};
				m_tuser_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	a_one_pixel_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("pixel accepted while previous pixel in flight");

	a_done_only_in_math: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == S_MATH))
		else $error("variance unit finished outside math state");

	a_load_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD && m_tvalid && !m_tready) |=> (state_q == S_LOAD))
		else $error("result loaded over pending beat");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[50:28] == '0))
		else $error("empty region with nonzero count");

endmodule
`default_nettype wire

// ===== src/lve_ram.sv =====
// ----------------------------------------------------------------------------
// lve_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module lve_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== src/lve_var_unit.sv =====
// ----------------------------------------------------------------------------
// lve_var_unit
// Sequential variance unit: shift-add products, then restoring division of
// 256*(n*sq - sum^2) by n^2, saturated to 28 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module lve_var_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lve_pkg::var_req_t req,
	output lve_pkg::var_rsp_t      rsp
);

	localparam int AW  = 66;
	localparam int BW  = 68;
	localparam int DW  = 46;
	localparam int NUMW = 74;

	typedef enum logic [4:0] {
		M_IDLE = 5'b00001,
		M_MUL  = 5'b00010,
		M_SUB  = 5'b00100,
		M_DIV  = 5'b01000,
		M_DONE = 5'b10000
	} mstate_t;

	mstate_t state_q;
	logic [6:0] cnt_q;
	logic [lve_pkg::CNT_W-1:0] nsh_q;
	logic [lve_pkg::SUM_W-1:0] msh_q;
	logic [AW-1:0] sqsh_q, a_q;
	logic [BW-1:0] magsh_q, b_q;
	logic [DW-1:0] nshl_q, d_q, r_q;
	logic [NUMW-1:0] num_q;
	logic [lve_pkg::VAR_W-1:0] q_q;
	logic over_q;

	logic [lve_pkg::SUM_W-1:0] mag;
	logic [DW:0] r_try;
	logic [DW:0] r_sub;
	logic qbit;

	assign mag = req.sum[lve_pkg::SUM_W-1] ? (~req.sum + 1'b1) : req.sum;
	assign r_try = {r_q, num_q[NUMW-1]};
	assign r_sub = r_try - {1'b0, d_q};
	assign qbit = (r_try >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				M_IDLE: begin
					if (req.start) begin
						state_q <= M_MUL;
						cnt_q <= 7'(lve_pkg::SUM_W - 1);
					end
				end
				M_MUL: begin
					if (cnt_q == '0) begin
						state_q <= M_SUB;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				M_SUB: begin
					state_q <= (a_q < b_q[AW-1:0] || b_q[BW-1:AW] != '0) ? M_DONE : M_DIV;
					cnt_q <= 7'(NUMW - 1);
				end
				M_DIV: begin
					if (cnt_q == '0) begin
						state_q <= M_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				M_DONE: state_q <= M_IDLE;
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				nsh_q <= req.n;
				msh_q <= mag;
				sqsh_q <= AW'(req.sq);
				magsh_q <= BW'(mag);
				nshl_q <= DW'(req.n);
				a_q <= '0;
				b_q <= '0;
				d_q <= '0;
			end
			M_MUL: begin
				if (nsh_q[0]) begin
					a_q <= a_q + sqsh_q;
					d_q <= d_q + nshl_q;
				end
				if (msh_q[0]) begin
					b_q <= b_q + magsh_q;
				end
				nsh_q <= nsh_q >> 1;
				msh_q <= msh_q >> 1;
				sqsh_q <= sqsh_q << 1;
				magsh_q <= magsh_q << 1;
				nshl_q <= nshl_q << 1;
			end
			M_SUB: begin
				num_q <= {a_q - b_q[AW-1:0], 8'd0};
				r_q <= '0;
				q_q <= '0;
				over_q <= 1'b0;
			end
			M_DIV: begin
				r_q <= qbit ? r_sub[DW-1:0] : r_try[DW-1:0];
				num_q <= num_q << 1;
				q_q <= {q_q[lve_pkg::VAR_W-2:0], qbit};
				if (qbit && cnt_q >= 7'(lve_pkg::VAR_W)) begin
					over_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = (state_q == M_DONE);
	assign rsp.variance = (over_q && cnt_q == '0 && num_q != '1) ? '1 :
		(over_q ? '1 : q_q);

endmodule
`default_nettype wire
